[hdl/page_table_walker_with_free_list_macros.svh]
// Assertion macros shared by the page table walker modules.
`ifndef PAGE_TABLE_WALKER_WITH_FREE_LIST_MACROS_SVH
`define PAGE_TABLE_WALKER_WITH_FREE_LIST_MACROS_SVH
`ifndef SYNTHESIS
`define PTWFL_ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define PTWFL_ASSERT(label, prop) `PTWFL_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define PTWFL_ASSERT_CLK(label, clk, rstn, prop)
`define PTWFL_ASSERT(label, prop)
`endif
`endif

[hdl/ptwfl_pkg.sv]
// Types and constants of the page table walker with free list.
`default_nettype none
package ptwfl_pkg;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_SETHEAD = 3'd2,
    OP_LOOKUP  = 3'd3,
    OP_MAP     = 3'd4,
    OP_ALLOC   = 3'd5,
    OP_FREE    = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_MISALIGN = 2'd2,
    ST_RANGE    = 2'd3
  } st_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RAW_RD, S_WALK, S_WALK_CHK, S_POP_CHK, S_LK_RD,
    S_CLR, S_CLR_ENT, S_MAP_RQ, S_MAP_WR, S_AL_RDE, S_AL_RDL, S_AL_CHK,
    S_AL_WE, S_AL_WP, S_FR_WL, S_FR_RQ, S_FR_WE, S_FIN
  } state_e;

  typedef enum logic [2:0] {RA_WIDX, RA_WALK, RA_HEAD, RA_LOC, RA_PA} ra_sel_e;
  typedef enum logic [2:0] {WA_WIDX, WA_CLR, WA_LOGLOC, WA_LOC, WA_PA} wa_sel_e;
  typedef enum logic [2:0] {
    WD_DATA, WD_ZERO, WD_LOGVAL, WD_MAPFIN, WD_ALLOC, WD_FREELINK, WD_FREEENT
  } wd_sel_e;
  typedef enum logic {VS_WD, VS_RD} val_sel_e;

  localparam logic [63:0] FLAG_P  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] FLAG_W  = 64'h0000_0000_0000_0002;
  localparam logic [63:0] FLAG_S  = 64'h0000_0000_0000_0004;
  localparam logic [63:0] FLAG_NX = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic     capture;
    logic     rd;
    ra_sel_e  ra;
    logic     wr;
    wa_sel_e  wa;
    wd_sel_e  wd;
    logic     set_st;
    st_e      st;
    logic     init_walk;
    logic     step;
    logic     pop;
    logic     set_loc;
    logic     set_loc_widx;
    logic     set_val;
    val_sel_e vs;
    logic     clr_start;
    logic     clr_step;
    logic     ent_step;
    logic     v_load;
    logic     lk_load;
    logic     head_from_hd;
    logic     head_from_page;
    logic     head_from_lk;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic widx_oob;
    logic page_zero;
    logic page_ok;
    logic phys_mis;
    logic root_oob;
    logic head_zero;
    logic hd_zero;
    logic at_target;
    logic e_present;
    logic nf_oob;
    logic pop_ok;
    logic lk_ok;
    logic loc_is_pa;
    logic n_zero;
    logic clr_last;
    logic ent_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[hdl/ptwfl_ram.sv]
// Generic single write port RAM with a registered read port.
`default_nettype none
module ptwfl_ram #(
  parameter int W = 64,
  parameter int D = 8192
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic                 re_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

[hdl/ptwfl_ctrl.sv]
// Controller state machine sequencing walks, table clearing and list updates.
`default_nettype none
`include "page_table_walker_with_free_list_macros.svh"
module ptwfl_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ptwfl_pkg::sts_t sts_i,
  output ptwfl_pkg::cmd_t     cmd_o
);
  import ptwfl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (sts_i.op)
          OP_WRITE: state_d = S_FIN;
          OP_READ: state_d = sts_i.widx_oob ? S_FIN : S_RAW_RD;
          OP_SETHEAD: state_d = S_FIN;
          OP_LOOKUP: state_d = sts_i.root_oob ? S_FIN : S_WALK;
          OP_MAP: state_d = (sts_i.phys_mis || sts_i.root_oob) ? S_FIN : S_WALK;
          OP_ALLOC: state_d = (sts_i.head_zero || sts_i.root_oob) ? S_FIN : S_WALK;
          OP_FREE: begin
            if (sts_i.page_zero || !sts_i.page_ok || sts_i.root_oob) begin
              state_d = S_FIN;
            end else begin
              state_d = S_WALK;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_RAW_RD: state_d = S_FIN;
      S_WALK: begin
        if (sts_i.at_target) begin
          case (sts_i.op)
            OP_LOOKUP: state_d = S_LK_RD;
            OP_MAP: state_d = sts_i.n_zero ? S_MAP_RQ : S_CLR;
            OP_ALLOC: state_d = S_AL_RDE;
            OP_FREE: state_d = S_FR_WL;
            default: state_d = S_FIN;
          endcase
        end else begin
          state_d = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (sts_i.op == OP_MAP && !sts_i.e_present) begin
          state_d = sts_i.hd_zero ? S_FIN : S_POP_CHK;
        end else begin
          state_d = sts_i.nf_oob ? S_FIN : S_WALK;
        end
      end
      S_POP_CHK: state_d = sts_i.pop_ok ? S_WALK : S_FIN;
      S_LK_RD: state_d = S_FIN;
      S_CLR: if (sts_i.clr_last) state_d = S_CLR_ENT;
      S_CLR_ENT: state_d = sts_i.ent_last ? S_MAP_RQ : S_CLR;
      S_MAP_RQ: state_d = S_MAP_WR;
      S_MAP_WR: state_d = S_FIN;
      S_AL_RDE: state_d = sts_i.loc_is_pa ? S_AL_CHK : S_AL_RDL;
      S_AL_RDL: state_d = S_AL_CHK;
      S_AL_CHK: state_d = sts_i.lk_ok ? S_AL_WE : S_FIN;
      S_AL_WE: state_d = S_AL_WP;
      S_AL_WP: state_d = S_FIN;
      S_FR_WL: state_d = S_FR_RQ;
      S_FR_RQ: state_d = S_FR_WE;
      S_FR_WE: state_d = S_FIN;
      S_FIN: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.ra = RA_WALK;
    cmd_o.wa = WA_LOC;
    cmd_o.wd = WD_ZERO;
    cmd_o.st = ST_OK;
    cmd_o.vs = VS_WD;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_WRITE, OP_READ: begin
            if (sts_i.widx_oob) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st = ST_RANGE;
            end else if (sts_i.op == OP_WRITE) begin
              cmd_o.wr = 1'b1;
              cmd_o.wa = WA_WIDX;
              cmd_o.wd = WD_DATA;
              cmd_o.set_val = 1'b1;
              cmd_o.set_loc_widx = 1'b1;
            end else begin
              cmd_o.rd = 1'b1;
              cmd_o.ra = RA_WIDX;
              cmd_o.set_loc_widx = 1'b1;
            end
          end
          OP_SETHEAD: begin
            if (!sts_i.page_ok) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st = ST_RANGE;
            end else begin
              cmd_o.head_from_page = 1'b1;
            end
          end
          OP_LOOKUP: begin
            cmd_o.set_st = sts_i.root_oob;
            cmd_o.st = ST_RANGE;
            cmd_o.init_walk = 1'b1;
          end
          OP_MAP: begin
            cmd_o.set_st = sts_i.phys_mis || sts_i.root_oob;
            cmd_o.st = sts_i.phys_mis ? ST_MISALIGN : ST_RANGE;
            cmd_o.init_walk = 1'b1;
          end
          OP_ALLOC: begin
            cmd_o.set_st = sts_i.head_zero || sts_i.root_oob;
            cmd_o.st = sts_i.head_zero ? ST_EMPTY : ST_RANGE;
            cmd_o.init_walk = 1'b1;
          end
          OP_FREE: begin
            cmd_o.set_st = !sts_i.page_zero && (!sts_i.page_ok || sts_i.root_oob);
            cmd_o.st = ST_RANGE;
            cmd_o.init_walk = 1'b1;
          end
          default: cmd_o.set_st = 1'b0;
        endcase
      end
      S_RAW_RD: begin
        cmd_o.set_val = 1'b1;
        cmd_o.vs = VS_RD;
      end
      S_WALK: begin
        cmd_o.rd = 1'b1;
        cmd_o.ra = RA_WALK;
        if (sts_i.at_target) begin
          cmd_o.set_loc = 1'b1;
          cmd_o.clr_start = 1'b1;
        end
      end
      S_WALK_CHK: begin
        if (sts_i.op == OP_MAP && !sts_i.e_present) begin
          cmd_o.set_st = sts_i.hd_zero;
          cmd_o.st = ST_EMPTY;
          cmd_o.rd = !sts_i.hd_zero;
          cmd_o.ra = RA_HEAD;
        end else begin
          cmd_o.set_st = sts_i.nf_oob;
          cmd_o.st = ST_RANGE;
          cmd_o.step = !sts_i.nf_oob;
        end
      end
      S_POP_CHK: begin
        cmd_o.set_st = !sts_i.pop_ok;
        cmd_o.st = ST_RANGE;
        cmd_o.pop = sts_i.pop_ok;
      end
      S_LK_RD: begin
        cmd_o.set_val = 1'b1;
        cmd_o.vs = VS_RD;
      end
      S_CLR: begin
        cmd_o.wr = 1'b1;
        cmd_o.wa = WA_CLR;
        cmd_o.wd = WD_ZERO;
        cmd_o.clr_step = 1'b1;
      end
      S_CLR_ENT: begin
        cmd_o.wr = 1'b1;
        cmd_o.wa = WA_LOGLOC;
        cmd_o.wd = WD_LOGVAL;
        cmd_o.ent_step = 1'b1;
      end
      S_MAP_RQ: begin
        cmd_o.rd = 1'b1;
        cmd_o.ra = RA_LOC;
      end
      S_MAP_WR: begin
        cmd_o.wr = 1'b1;
        cmd_o.wa = WA_LOC;
        cmd_o.wd = WD_MAPFIN;
        cmd_o.set_val = 1'b1;
        cmd_o.head_from_hd = 1'b1;
      end
      S_AL_RDE: begin
        cmd_o.v_load = 1'b1;
        cmd_o.rd = !sts_i.loc_is_pa;
        cmd_o.ra = RA_PA;
      end
      S_AL_RDL: cmd_o.lk_load = 1'b1;
      S_AL_CHK: begin
        cmd_o.set_st = !sts_i.lk_ok;
        cmd_o.st = ST_RANGE;
      end
      S_AL_WE: begin
        cmd_o.wr = 1'b1;
        cmd_o.wa = WA_LOC;
        cmd_o.wd = WD_ALLOC;
        cmd_o.set_val = 1'b1;
      end
      S_AL_WP: begin
        cmd_o.wr = 1'b1;
        cmd_o.wa = WA_PA;
        cmd_o.wd = WD_ZERO;
        cmd_o.set_val = sts_i.loc_is_pa;
        cmd_o.head_from_lk = 1'b1;
      end
      S_FR_WL: begin
        cmd_o.wr = 1'b1;
        cmd_o.wa = WA_PA;
        cmd_o.wd = WD_FREELINK;
      end
      S_FR_RQ: begin
        cmd_o.rd = 1'b1;
        cmd_o.ra = RA_LOC;
      end
      S_FR_WE: begin
        cmd_o.wr = 1'b1;
        cmd_o.wa = WA_LOC;
        cmd_o.wd = WD_FREEENT;
        cmd_o.set_val = 1'b1;
        cmd_o.head_from_page = 1'b1;
      end
      S_FIN: cmd_o.out_load = sts_i.out_free;
      default: in_ready_o = 1'b0;
    endcase
  end

  `PTWFL_ASSERT(a_accept_leaves_idle, (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
  `PTWFL_ASSERT(a_clear_needs_table, (state_q == S_CLR) |-> !sts_i.n_zero)
  `PTWFL_ASSERT(a_load_when_free, cmd_o.out_load |-> sts_i.out_free)
endmodule
`default_nettype wire

[hdl/ptwfl_dp.sv]
// Datapath: item registers, walk state, pending table log, table store and result.
`default_nettype none
module ptwfl_dp #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [3:0]      cfg_wdata_i,
  input  wire logic [231:0]    in_data_i,
  input  wire logic [2:0]      in_user_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic      [95:0]     out_data_o,
  output logic      [1:0]      out_user_o,
  input  wire ptwfl_pkg::cmd_t cmd_i,
  output ptwfl_pkg::sts_t      sts_o
);
  import ptwfl_pkg::*;

  localparam int FW = $clog2(TABLE_PAGES);
  localparam int AW = FW + 9;
  localparam int STORE_WORDS = TABLE_PAGES * 512;

  op_e            op_q;
  logic [47:0]    page_q, va_q;
  logic [1:0]     tl_q, lvl_q;
  logic [51:0]    phys_q;
  logic [12:0]    widx_q;
  logic [63:0]    data_q;
  logic [FW-1:0]  pa_q, fh_q, hd_q, cur_q;
  logic [3:0]     root_q;
  logic [AW-1:0]  at_q, raddr_q, loc_q;
  logic [FW-1:0]  lf_q [3];
  logic [AW-1:0]  ll_q [3];
  logic [1:0]     n_q, ci_q;
  logic [8:0]     cw_q;
  logic [63:0]    v_q, lk_q;
  st_e            res_st_q;
  logic [63:0]    res_val_q;
  logic [AW-1:0]  res_loc_q;
  logic [15:0]    res_alloc_q;
  logic           out_valid_q;
  logic [95:0]    out_data_q;
  logic [1:0]     out_user_q;

  logic [8:0]     sl;
  logic [AW-1:0]  walk_addr, ram_raddr, ram_waddr;
  logic [63:0]    rdata, ovrd, wdata;
  op_e            in_op;
  logic           out_free;

  function automatic logic lnk_ok(input logic [63:0] w);
    lnk_ok = (w == 64'd0) || (w[11:0] == 12'd0 && w[63:12] < 52'(TABLE_PAGES));
  endfunction

  always_comb begin
    case (lvl_q)
      2'd0: sl = va_q[20:12];
      2'd1: sl = va_q[29:21];
      2'd2: sl = va_q[38:30];
      default: sl = va_q[47:39];
    endcase
  end
  assign walk_addr = {cur_q, sl};

  always_comb begin
    case (cmd_i.ra)
      RA_WIDX: ram_raddr = AW'(widx_q);
      RA_HEAD: ram_raddr = {hd_q, 9'd0};
      RA_LOC:  ram_raddr = loc_q;
      RA_PA:   ram_raddr = {pa_q, 9'd0};
      default: ram_raddr = walk_addr;
    endcase
  end

  always_comb begin
    case (cmd_i.wa)
      WA_WIDX:   ram_waddr = AW'(widx_q);
      WA_CLR:    ram_waddr = {lf_q[ci_q], cw_q};
      WA_LOGLOC: ram_waddr = ll_q[ci_q];
      WA_PA:     ram_waddr = {pa_q, 9'd0};
      default:   ram_waddr = loc_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wd)
      WD_DATA:     wdata = data_q;
      WD_LOGVAL:   wdata = 64'({lf_q[ci_q], 12'd0}) | FLAG_P | FLAG_W | FLAG_S;
      WD_MAPFIN:   wdata = (rdata | 64'(phys_q) | FLAG_P | FLAG_W) & ~FLAG_NX;
      WD_ALLOC:    wdata = v_q | FLAG_W | FLAG_S | FLAG_NX;
      WD_FREELINK: wdata = 64'({fh_q, 12'd0});
      WD_FREEENT:  wdata = rdata & ~FLAG_P;
      default:     wdata = 64'd0;
    endcase
  end

  ptwfl_ram #(.W(64), .D(STORE_WORDS)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (ram_waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // Tables taken from the free list are only committed once the whole walk has passed,
  // so reads during the walk see them through the pending log, newest entry first.
  always_comb begin
    ovrd = rdata;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n_q) begin
        if (raddr_q == ll_q[i]) begin
          ovrd = 64'({lf_q[i], 12'd0}) | FLAG_P | FLAG_W | FLAG_S;
        end else if (raddr_q[AW-1:9] == lf_q[i]) begin
          ovrd = 64'd0;
        end
      end
    end
  end

  assign in_op = op_e'(in_user_i);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= 4'd0;
      fh_q <= '0;
      out_valid_q <= 1'b0;
      n_q <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      if (cmd_i.head_from_hd) begin
        fh_q <= hd_q;
      end else if (cmd_i.head_from_page) begin
        fh_q <= page_q[12 +: FW];
      end else if (cmd_i.head_from_lk) begin
        fh_q <= lk_q[12 +: FW];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.capture) begin
        n_q <= 2'd0;
      end else if (cmd_i.pop) begin
        n_q <= n_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= in_op;
      phys_q <= in_data_i[101:50];
      page_q <= in_data_i[149:102];
      widx_q <= in_data_i[162:150];
      data_q <= in_data_i[226:163];
      if (in_op == OP_ALLOC) begin
        va_q <= 48'({fh_q, 12'd0});
        pa_q <= fh_q;
      end else begin
        va_q <= (in_op == OP_FREE) ? in_data_i[149:102] : in_data_i[47:0];
        pa_q <= in_data_i[102+12 +: FW];
      end
      tl_q <= (in_op == OP_LOOKUP || in_op == OP_MAP) ? in_data_i[49:48] : 2'd0;
      res_st_q <= ST_OK;
      res_val_q <= 64'd0;
      res_loc_q <= '0;
      res_alloc_q <= 16'd0;
    end
    if (cmd_i.set_st) begin
      res_st_q <= cmd_i.st;
    end
    if (cmd_i.init_walk) begin
      cur_q <= FW'(root_q);
      lvl_q <= 2'd3;
      hd_q <= fh_q;
    end else if (cmd_i.step) begin
      cur_q <= ovrd[12 +: FW];
      lvl_q <= lvl_q - 2'd1;
    end else if (cmd_i.pop) begin
      lf_q[n_q] <= hd_q;
      ll_q[n_q] <= at_q;
      cur_q <= hd_q;
      hd_q <= ovrd[12 +: FW];
      lvl_q <= lvl_q - 2'd1;
    end
    if (cmd_i.rd) begin
      raddr_q <= ram_raddr;
      if (cmd_i.ra == RA_WALK) begin
        at_q <= walk_addr;
      end
    end
    if (cmd_i.set_loc) begin
      loc_q <= walk_addr;
      res_loc_q <= walk_addr;
    end else if (cmd_i.set_loc_widx) begin
      res_loc_q <= AW'(widx_q);
    end
    if (cmd_i.set_val) begin
      res_val_q <= (cmd_i.vs == VS_RD) ? rdata : wdata;
    end
    if (cmd_i.clr_start) begin
      ci_q <= 2'd0;
      cw_q <= 9'd0;
    end else begin
      if (cmd_i.clr_step) begin
        cw_q <= cw_q + 9'd1;
      end
      if (cmd_i.ent_step) begin
        ci_q <= ci_q + 2'd1;
      end
    end
    if (cmd_i.v_load) begin
      v_q <= rdata | FLAG_P;
      lk_q <= rdata | FLAG_P;
    end else if (cmd_i.lk_load) begin
      lk_q <= rdata;
    end
    if (cmd_i.head_from_lk) begin
      res_alloc_q <= 16'({pa_q, 12'd0});
    end
    if (cmd_i.out_load) begin
      out_user_q <= res_st_q;
      if (res_st_q == ST_OK) begin
        out_data_q <= {3'd0, res_alloc_q, 13'(res_loc_q), res_val_q};
      end else begin
        out_data_q <= 96'd0;
      end
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.widx_oob  = 32'(widx_q) >= 32'(STORE_WORDS);
    sts_o.page_zero = page_q == 48'd0;
    sts_o.page_ok   = lnk_ok(64'(page_q));
    sts_o.phys_mis  = phys_q[11:0] != 12'd0;
    sts_o.root_oob  = 32'(root_q) >= 32'(TABLE_PAGES);
    sts_o.head_zero = fh_q == '0;
    sts_o.hd_zero   = hd_q == '0;
    sts_o.at_target = lvl_q == tl_q;
    sts_o.e_present = ovrd[0];
    sts_o.nf_oob    = 64'(ovrd[50:12]) >= 64'(TABLE_PAGES);
    sts_o.pop_ok    = lnk_ok(ovrd);
    sts_o.lk_ok     = lnk_ok(lk_q);
    sts_o.loc_is_pa = loc_q == {pa_q, 9'd0};
    sts_o.n_zero    = n_q == 2'd0;
    sts_o.clr_last  = cw_q == 9'h1FF;
    sts_o.ent_last  = ci_q == n_q - 2'd1;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;
endmodule
`default_nettype wire

[hdl/page_table_walker_with_free_list.sv]
// Top level of the four-level page table walker with an internal table store.
// Items arrive on the s_axis channel, one operation each, and every item gives one
// result item on the m_axis channel. tuser carries the operation in and the status out.
// Items are handled one at a time; a new item is taken while the previous result waits.
// Map clears every new table taken from the free list, one store word a cycle.
// The store has one write and one read port with a registered read, so every walk
// level costs a read and a check.
// cfg_we_i writes the root frame; it may only change while the block is idle.
// Reset clears the root frame and the free list head; the table store is not cleared
// and words must be written before they are read.
// When the receiver stalls, the result stays in the output register and the block
// finishes at most one further item before it waits.
`default_nettype none
`include "page_table_walker_with_free_list_macros.svh"
module page_table_walker_with_free_list #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [3:0]   cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // address, level, physical address, page_address, word_index, word_data, from bit 0 up
  input  wire logic [231:0] s_axis_tdata,
  // operation
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // entry_value, entry_location, allocated_page, from bit 0 up
  output logic      [95:0]  m_axis_tdata,
  // status
  output logic      [1:0]   m_axis_tuser
);
  import ptwfl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptwfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptwfl_dp #(.TABLE_PAGES(TABLE_PAGES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `PTWFL_ASSERT(a_error_clears_fields,
                (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 96'd0))
endmodule
`default_nettype wire
